>>> hdl/c6502_pkg.sv
package c6502_pkg;

  // Memory address width; the program counter itself is always 16 bits
  localparam int ADDR_WIDTH = 16;

  localparam logic [15:0] PC_RESET = 16'h0600;

  // Request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EXEC  = 1'b1;

  // Known opcodes
  localparam logic [7:0] OP_ADC_IMM = 8'h69;
  localparam logic [7:0] OP_INX     = 8'hE8;
  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_LDA_ABS = 8'hAD;
  localparam logic [7:0] OP_STA_ABS = 8'h8D;
  localparam logic [7:0] OP_TAX     = 8'hAA;

  // ALU operations
  localparam logic [2:0] ALU_NOP = 3'd0;
  localparam logic [2:0] ALU_ADC = 3'd1;
  localparam logic [2:0] ALU_LDA = 3'd2;
  localparam logic [2:0] ALU_INX = 3'd3;
  localparam logic [2:0] ALU_TAX = 3'd4;

  typedef struct packed {
    logic        req_type;
    logic [15:0] mem_address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_acc;
    logic [7:0]  out_x;
    logic [15:0] out_pc;
    logic        out_negative;
    logic        out_overflow;
    logic        out_zero;
    logic        out_carry;
    logic        bad_opcode;
  } out_item_t;

  // Architectural registers apart from the program counter
  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic       n;
    logic       v;
    logic       z;
    logic       c;
  } regs_t;

endpackage

>>> hdl/c6502_ram.sv
module c6502_ram #(
  parameter int AW = 16,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [(1 << AW)];

  // Write the addressed byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

endmodule

>>> hdl/c6502_alu.sv
module c6502_alu (
  input  logic [2:0]       alu_op,
  input  logic [7:0]       operand,
  input  c6502_pkg::regs_t regs_in,
  output c6502_pkg::regs_t regs_out
);

  logic [8:0] sum;
  logic [7:0] res;

  // Add with carry
  assign sum = {1'b0, regs_in.acc} + {1'b0, operand} + {8'd0, regs_in.c};
  assign res = sum[7:0];

  always_comb begin
    regs_out = regs_in;
    unique case (alu_op)
      c6502_pkg::ALU_NOP: begin
      end
      c6502_pkg::ALU_ADC: begin
        regs_out.acc = res;
        regs_out.c   = sum[8];
        regs_out.v   = ~(regs_in.acc[7] ^ operand[7]) & (regs_in.acc[7] ^ res[7]);
        regs_out.n   = res[7];
        regs_out.z   = (res == 8'd0);
      end
      c6502_pkg::ALU_LDA: begin
        regs_out.acc = operand;
        regs_out.n   = operand[7];
        regs_out.z   = (operand == 8'd0);
      end
      c6502_pkg::ALU_INX: begin
        regs_out.x = regs_in.x + 8'd1;
        regs_out.n = regs_out.x[7];
        regs_out.z = (regs_out.x == 8'd0);
      end
      c6502_pkg::ALU_TAX: begin
        regs_out.x = regs_in.acc;
        regs_out.n = regs_in.acc[7];
        regs_out.z = (regs_in.acc == 8'd0);
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/cpu6502_subset_core.sv
// Channel   Ports                      Beat
// ------    -------------------------  -----------------------------------------
// input     start, busy, in_item       taken at a clock edge with start & !busy
// result    out_valid, out_item        shown for one cycle after the item ends
//
// Steps follow the single memory port, one byte of opcode, operand, address or
// data per cycle: a write stores its byte; an instruction reads its opcode, then
// any operand or address bytes; STA and LDA absolute then write or read data.
// Synchronous active-low reset loads PC with 0x0600 and clears A, X and flags;
// memory contents are undefined until written. The receiver cannot stall.
module cpu6502_subset_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  c6502_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output c6502_pkg::out_item_t out_item
);

  localparam int AW = c6502_pkg::ADDR_WIDTH;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_OP   = 3'd1;
  localparam logic [2:0] ST_IMM  = 3'd2;
  localparam logic [2:0] ST_LO   = 3'd3;
  localparam logic [2:0] ST_HI   = 3'd4;
  localparam logic [2:0] ST_DATA = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [15:0]      pc_r, pc_nxt;
  c6502_pkg::regs_t regs_r, regs_nxt;
  logic [7:0]       op_r, op_nxt;
  logic [7:0]       lo_r, lo_nxt;
  logic             bad_r, bad_nxt;
  logic             out_valid_r, done;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;
  logic [2:0]    alu_op;
  logic [15:0]   abs_addr;

  c6502_ram #(.AW(AW), .DW(8)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  c6502_alu u_alu (
    .alu_op   (alu_op),
    .operand  (ram_rdata),
    .regs_in  (regs_r),
    .regs_out (regs_nxt)
  );

  assign abs_addr = {ram_rdata, lo_r};

  // Sequence memory accesses of one write request or instruction
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    op_nxt    = op_r;
    lo_nxt    = lo_r;
    bad_nxt   = bad_r;
    done      = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = pc_r[AW-1:0];
    ram_wdata = 8'h00;
    alu_op    = c6502_pkg::ALU_NOP;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          bad_nxt = 1'b0;
          if (in_item.req_type == c6502_pkg::REQ_WRITE) begin
            ram_we    = 1'b1;
            ram_addr  = in_item.mem_address[AW-1:0];
            ram_wdata = in_item.write_data;
            done      = 1'b1;
          end else begin
            pc_nxt    = pc_r + 16'd1;
            state_nxt = ST_OP;
          end
        end
      end
      ST_OP: begin
        op_nxt = ram_rdata;
        unique case (ram_rdata) inside
          c6502_pkg::OP_INX: begin
            alu_op    = c6502_pkg::ALU_INX;
            done      = 1'b1;
            state_nxt = ST_IDLE;
          end
          c6502_pkg::OP_TAX: begin
            alu_op    = c6502_pkg::ALU_TAX;
            done      = 1'b1;
            state_nxt = ST_IDLE;
          end
          c6502_pkg::OP_ADC_IMM, c6502_pkg::OP_LDA_IMM: begin
            pc_nxt    = pc_r + 16'd1;
            state_nxt = ST_IMM;
          end
          c6502_pkg::OP_LDA_ABS, c6502_pkg::OP_STA_ABS: begin
            pc_nxt    = pc_r + 16'd1;
            state_nxt = ST_LO;
          end
          default: begin
            // unknown opcode: clear the byte after it
            ram_we    = 1'b1;
            bad_nxt   = 1'b1;
            done      = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_IMM: begin
        alu_op    = (op_r == c6502_pkg::OP_ADC_IMM) ? c6502_pkg::ALU_ADC
                                                    : c6502_pkg::ALU_LDA;
        done      = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_LO: begin
        lo_nxt    = ram_rdata;
        pc_nxt    = pc_r + 16'd1;
        state_nxt = ST_HI;
      end
      ST_HI: begin
        ram_addr = abs_addr[AW-1:0];
        if (op_r == c6502_pkg::OP_STA_ABS) begin
          ram_we    = 1'b1;
          ram_wdata = regs_r.acc;
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_DATA;
        end
      end
      ST_DATA: begin
        alu_op    = c6502_pkg::ALU_LDA;
        done      = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Advance control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= c6502_pkg::PC_RESET;
      regs_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      regs_r      <= regs_nxt;
      out_valid_r <= done;
    end
  end

  // Hold datapath scratch values
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    lo_r  <= lo_nxt;
    bad_r <= bad_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Drive the result beat from the current registers
  always_comb begin
    out_item.out_acc      = regs_r.acc;
    out_item.out_x        = regs_r.x;
    out_item.out_pc       = pc_r;
    out_item.out_negative = regs_r.n;
    out_item.out_overflow = regs_r.v;
    out_item.out_zero     = regs_r.z;
    out_item.out_carry    = regs_r.c;
    out_item.bad_opcode   = bad_r;
  end

endmodule

>>> tb/sv/cpu6502_subset_core_test.sv
`timescale 1ns / 100ps

module cpu6502_subset_core_test;

  localparam int MEM_DEPTH    = 1 << c6502_pkg::ADDR_WIDTH;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_BEATS = 700;
  localparam int MAX_REPORTS  = 10;

  // Any byte outside the decoded set
  localparam logic [7:0] OP_UNDEF = 8'h02;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  c6502_pkg::in_item_t  in_item = '0;
  logic                 out_valid;
  c6502_pkg::out_item_t out_item;

  cpu6502_subset_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // Architectural shadow: memory image, which bytes hold data, registers and PC
  logic [7:0]       mem_img [MEM_DEPTH];
  bit               mem_valid [MEM_DEPTH];
  logic [15:0]      written_list [$];
  c6502_pkg::regs_t arch;
  logic [15:0]      pc_arch;

  // Register file and flags expected after each accepted beat, oldest first
  c6502_pkg::out_item_t arch_after_q [$];

  int          mismatch_cnt = 0;
  int          cycle_cnt = 0;
  int          beat_cnt = 0;
  bit          no_idle = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [c6502_pkg::ADDR_WIDTH-1:0] mem_index(logic [15:0] addr);
    return addr[c6502_pkg::ADDR_WIDTH-1:0];
  endfunction

  function automatic bit is_known(logic [7:0] op);
    return op inside {c6502_pkg::OP_ADC_IMM, c6502_pkg::OP_INX, c6502_pkg::OP_LDA_IMM,
                      c6502_pkg::OP_LDA_ABS, c6502_pkg::OP_STA_ABS, c6502_pkg::OP_TAX};
  endfunction

  function automatic void mem_store(logic [15:0] addr, logic [7:0] data);
    if (!mem_valid[mem_index(addr)]) written_list.push_back(addr);
    mem_valid[mem_index(addr)] = 1'b1;
    mem_img[mem_index(addr)] = data;
  endfunction

  function automatic logic [7:0] fetch_byte();
    logic [7:0] b;
    b = mem_img[mem_index(pc_arch)];
    pc_arch = pc_arch + 16'd1;
    return b;
  endfunction

  function automatic void set_nz(logic [7:0] v);
    arch.z = (v == 8'h00);
    arch.n = v[7];
  endfunction

  // Apply one beat to the shadow state and return the registers it leaves
  function automatic c6502_pkg::out_item_t advance_arch(c6502_pkg::in_item_t it);
    c6502_pkg::out_item_t res;
    logic [7:0]           op;
    logic [7:0]           m;
    logic [7:0]           r;
    logic [8:0]           sum;
    logic [15:0]          ea;
    res = '0;
    if (it.req_type == c6502_pkg::REQ_WRITE) begin
      mem_store(it.mem_address, it.write_data);
    end else begin
      op = fetch_byte();
      case (op)
        c6502_pkg::OP_ADC_IMM: begin
          m = fetch_byte();
          sum = {1'b0, arch.acc} + {1'b0, m} + {8'd0, arch.c};
          r = sum[7:0];
          arch.c = sum[8];
          arch.v = ~(arch.acc[7] ^ m[7]) & (arch.acc[7] ^ r[7]);
          arch.acc = r;
          set_nz(r);
        end
        c6502_pkg::OP_INX: begin
          arch.x = arch.x + 8'd1;
          set_nz(arch.x);
        end
        c6502_pkg::OP_LDA_IMM: begin
          arch.acc = fetch_byte();
          set_nz(arch.acc);
        end
        c6502_pkg::OP_LDA_ABS: begin
          ea[7:0] = fetch_byte();
          ea[15:8] = fetch_byte();
          arch.acc = mem_img[mem_index(ea)];
          set_nz(arch.acc);
        end
        c6502_pkg::OP_STA_ABS: begin
          ea[7:0] = fetch_byte();
          ea[15:8] = fetch_byte();
          mem_store(ea, arch.acc);
        end
        c6502_pkg::OP_TAX: begin
          arch.x = arch.acc;
          set_nz(arch.x);
        end
        default: begin
          // PC already points past the bad opcode; clear the byte there
          mem_store(pc_arch, 8'h00);
          res.bad_opcode = 1'b1;
        end
      endcase
    end
    res.out_acc = arch.acc;
    res.out_x = arch.x;
    res.out_pc = pc_arch;
    res.out_negative = arch.n;
    res.out_overflow = arch.v;
    res.out_zero = arch.z;
    res.out_carry = arch.c;
    return res;
  endfunction

  // True when executing at PC reads only bytes that were written
  function automatic bit exec_ready();
    logic [7:0]  op;
    logic [15:0] ea;
    if (!mem_valid[mem_index(pc_arch)]) return 1'b0;
    op = mem_img[mem_index(pc_arch)];
    case (op) inside
      c6502_pkg::OP_ADC_IMM, c6502_pkg::OP_LDA_IMM: begin
        return mem_valid[mem_index(pc_arch + 16'd1)];
      end
      c6502_pkg::OP_STA_ABS: begin
        return mem_valid[mem_index(pc_arch + 16'd1)] &&
               mem_valid[mem_index(pc_arch + 16'd2)];
      end
      c6502_pkg::OP_LDA_ABS: begin
        if (!mem_valid[mem_index(pc_arch + 16'd1)] || !mem_valid[mem_index(pc_arch + 16'd2)])
          return 1'b0;
        ea = {mem_img[mem_index(pc_arch + 16'd2)], mem_img[mem_index(pc_arch + 16'd1)]};
        return mem_valid[mem_index(ea)];
      end
      default: return 1'b1;
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] corners [5] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(0, 3) == 0) return corners[3'($urandom_range(0, 4))];
    return 8'($urandom);
  endfunction

  function automatic void report_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endfunction

  function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) report_mismatch($sformatf("%s: expected %h, got %h", name, want, got));
  endfunction

  // Check each result beat against the oldest outstanding expectation
  always @(posedge clk) begin
    c6502_pkg::out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (arch_after_q.size() == 0) begin
        report_mismatch("result beat with nothing outstanding");
      end else begin
        want = arch_after_q.pop_front();
        cmp_field("out_acc", 16'(want.out_acc), 16'(out_item.out_acc));
        cmp_field("out_x", 16'(want.out_x), 16'(out_item.out_x));
        cmp_field("out_pc", want.out_pc, out_item.out_pc);
        cmp_field("out_negative", 16'(want.out_negative), 16'(out_item.out_negative));
        cmp_field("out_overflow", 16'(want.out_overflow), 16'(out_item.out_overflow));
        cmp_field("out_zero", 16'(want.out_zero), 16'(out_item.out_zero));
        cmp_field("out_carry", 16'(want.out_carry), 16'(out_item.out_carry));
        cmp_field("bad_opcode", 16'(want.bad_opcode), 16'(out_item.bad_opcode));
      end
    end else if (rst_n && out_valid !== 1'b0) begin
      report_mismatch("out_valid unknown");
    end
  end

  // Hold start until the beat is taken, record its outcome, then maybe idle
  task automatic send_beat(input c6502_pkg::in_item_t it);
    if (!start) start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    arch_after_q.push_back(advance_arch(it));
    beat_cnt++;
    if (!no_idle && $urandom_range(0, 99) < 34) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic put_byte(input logic [15:0] addr, input logic [7:0] data);
    c6502_pkg::in_item_t it;
    it.req_type = c6502_pkg::REQ_WRITE;
    it.mem_address = addr;
    it.write_data = data;
    send_beat(it);
  endtask

  // Address and data are don't-care on an execute beat; drive them random
  task automatic run_insn();
    c6502_pkg::in_item_t it;
    it.req_type = c6502_pkg::REQ_EXEC;
    it.mem_address = 16'($urandom);
    it.write_data = 8'($urandom);
    send_beat(it);
  endtask

  // Load one random instruction at PC and execute it
  task automatic load_and_run();
    logic [7:0]  op;
    logic [15:0] ea;
    logic [15:0] at;
    at = pc_arch;
    case ($urandom_range(0, 6))
      0: op = c6502_pkg::OP_ADC_IMM;
      1: op = c6502_pkg::OP_INX;
      2: op = c6502_pkg::OP_LDA_IMM;
      3: op = c6502_pkg::OP_LDA_ABS;
      4: op = c6502_pkg::OP_STA_ABS;
      5: op = c6502_pkg::OP_TAX;
      default: begin
        do op = 8'($urandom); while (is_known(op));
      end
    endcase
    put_byte(at, op);
    if (op == c6502_pkg::OP_ADC_IMM || op == c6502_pkg::OP_LDA_IMM) begin
      put_byte(at + 16'd1, pick_byte());
    end else if (op == c6502_pkg::OP_LDA_ABS || op == c6502_pkg::OP_STA_ABS) begin
      // Loads only read bytes that hold data; stores go anywhere
      if (op == c6502_pkg::OP_LDA_ABS || $urandom_range(0, 1) == 0)
        ea = written_list[$urandom_range(0, written_list.size() - 1)];
      else
        ea = 16'($urandom);
      put_byte(at + 16'd1, ea[7:0]);
      put_byte(at + 16'd2, ea[15:8]);
    end
    run_insn();
  endtask

  task automatic test_write_extremes();
    put_byte(16'h0000, 8'hFF);
    put_byte(16'hFFFF, 8'h00);
  endtask

  // Every opcode, ADC twice, with carry out, signed overflow, zero and negative results
  task automatic test_all_opcodes();
    logic [7:0]  prog [15] = '{c6502_pkg::OP_LDA_IMM, 8'hFF, c6502_pkg::OP_ADC_IMM, 8'h01,
                               c6502_pkg::OP_ADC_IMM, 8'h7F, c6502_pkg::OP_TAX,
                               c6502_pkg::OP_INX, c6502_pkg::OP_STA_ABS, 8'h00, 8'h00,
                               c6502_pkg::OP_LDA_ABS, 8'hFF, 8'hFF, OP_UNDEF};
    logic [15:0] base;
    base = pc_arch;
    foreach (prog[i]) put_byte(base + 16'(i), prog[i]);
    repeat (8) run_insn();
  endtask

  // Mostly loaded instructions, plus stray writes and reruns of what sits at PC
  task automatic test_random_programs();
    int first;
    int roll;
    first = beat_cnt;
    while (beat_cnt - first < RANDOM_BEATS) begin
      no_idle = (beat_cnt - first) inside {[300:419]};
      roll = $urandom_range(0, 99);
      if (roll < 75) load_and_run();
      else if (roll < 88 && exec_ready()) run_insn();
      else put_byte(16'($urandom), 8'($urandom));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    arch = '0;
    pc_arch = c6502_pkg::PC_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_write_extremes();
    test_all_opcodes();
    test_random_programs();

    // Drain outstanding results, then allow for stray beats
    start <= 1'b0;
    @(posedge clk);
    while (arch_after_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
